FILE: design/fixed_block_free_list_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block free list unit
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define FBFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FBFL_ASSERT_IMPL(lbl, ante, cons, msg) \
  `FBFL_ASSERT(lbl, (ante) |-> (cons), msg)

`else

`define FBFL_ASSERT(lbl, prop, msg)

`define FBFL_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

FILE: design/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types, codes and default sizes shared by the fixed block free list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

  localparam int NumBlocksDef = 256;
  localparam int WordBytesDef = 8;

  localparam int CfgDataW   = 13;
  localparam int CfgIndexW  = 1;
  localparam int ModeW      = 2;
  localparam int IndexW     = 8;
  localparam int OffsetW    = 21;
  localparam int StatusW    = 2;
  localparam int CountW     = 9;
  localparam int PoolLimit  = 256;

  localparam logic [CfgIndexW-1:0] CFG_BLOCK_BYTES   = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  localparam logic [ModeW-1:0] MODE_ALLOC = 2'd0;
  localparam logic [ModeW-1:0] MODE_FREE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_RESET = 2'd2;

  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [StatusW-1:0] STAT_BAD_INDEX = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

endpackage

`default_nettype wire

FILE: design/fixed_block_free_list_unit.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_unit
// Allocator for a pool of equal-size blocks kept as a LIFO free list.
// ----------------------------------------------------------------------------
// Each request runs as a transfer and an execute step: the cycle of its
// transfer reads the link memory at the current list head, and the execute
// state, once the output can take a result, updates the head, the fresh mark
// and the used count and loads the result register. A new request is taken
// only after the unit has returned to idle, so it cannot take one before the
// previous one is loaded. The input stalls during a configuration write, and
// a write to either register makes the whole pool free again. No clearing
// pass follows reset: a link is only used after it has been written.
`default_nettype none

`include "fixed_block_free_list_unit_macros.svh"

module fixed_block_free_list_unit
  import fbfl_pkg::*;
#(
  parameter int NUM_BLOCKS = NumBlocksDef,
  parameter int WORD_BYTES = WordBytesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ModeW-1:0]     mode_i,
  input  wire logic [IndexW-1:0]    free_index_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [IndexW-1:0]    block_index_o,
  output logic      [OffsetW-1:0]   block_offset_o,
  output logic      [StatusW-1:0]   status_o,
  output logic      [CountW-1:0]    free_count_o
);

  localparam int AddrW      = $clog2(NUM_BLOCKS);
  localparam int LinkW      = $clog2(NUM_BLOCKS + 1);
  localparam int PoolMax    = (NUM_BLOCKS < PoolLimit) ? NUM_BLOCKS : PoolLimit;
  localparam int XW         = CfgDataW + 1;
  localparam int RecipShift = XW + $clog2(WORD_BYTES);
  localparam int RecipW     = RecipShift + 1;
  localparam longint RecipMul = ((64'd1 << RecipShift) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int QuotRst    = (8 + WORD_BYTES - 1) / WORD_BYTES;
  localparam int ProdW      = IndexW + XW;
  localparam int SumW       = ProdW + 1;

  localparam logic [LinkW-1:0]  EmptyMark = LinkW'(NUM_BLOCKS);
  localparam logic [CountW-1:0] PoolMaxC  = CountW'(PoolMax);

  state_e state_q, state_d;

  logic [XW-1:0]     quot_q, quot_d;
  logic [XW-1:0]     stride_q;
  logic [CountW-1:0] biu_q;
  logic [LinkW-1:0]  head_q, head_d;
  logic [CountW-1:0] fresh_q, fresh_d;
  logic [CountW-1:0] used_q, used_d;

  logic [ModeW-1:0]  req_mode_q;
  logic [IndexW-1:0] req_idx_q;

  logic               out_valid_q;
  logic [IndexW-1:0]  res_index_q, res_index_d;
  logic [OffsetW-1:0] res_offset_q, res_offset_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [CountW-1:0]  res_count_q, res_count_d;

  logic              in_xfer;
  logic              commit;
  logic [CountW-1:0] pool_n;
  logic              head_valid;
  logic [LinkW-1:0]  rd_link;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic              res_fail;

  logic [CfgDataW-1:0]   bytes_nz;
  logic [XW-1:0]         round_x;
  logic [XW+RecipW-1:0]  recip_prod;

  logic [LinkW+IndexW-1:0] head_ext;
  logic [AddrW+IndexW-1:0] idx_ext;
  logic [CountW-1:0]       used_tmp;
  logic                    got;
  logic [ProdW-1:0]        off_prod;
  logic [SumW-1:0]         off_sum;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || cfg_we_i;
  assign commit     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  assign pool_n     = (biu_q > PoolMaxC) ? PoolMaxC : biu_q;
  assign head_valid = head_q < EmptyMark;
  assign head_ext   = (LinkW + IndexW)'(head_q);
  assign idx_ext    = (AddrW + IndexW)'(req_idx_q);

  assign bytes_nz   = (cfg_data_i == '0) ? CfgDataW'(1) : cfg_data_i;
  assign round_x    = XW'(bytes_nz) + XW'(WORD_BYTES - 1);
  assign recip_prod = (XW + RecipW)'(round_x) * (XW + RecipW)'(RecipMul);
  assign quot_d     = XW'(recip_prod >> RecipShift);

  fbfl_ram #(
    .WIDTH (LinkW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (head_q),
    .re_i    (in_xfer),
    .raddr_i (head_q[AddrW-1:0]),
    .rdata_o (rd_link)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fresh_d      = fresh_q;
    used_tmp     = used_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_ext[AddrW-1:0];
    got          = 1'b0;
    res_index_d  = '0;
    res_status_d = STAT_OK;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    case (req_mode_q)
      MODE_ALLOC: begin
        if (head_valid) begin
          res_index_d = head_ext[IndexW-1:0];
          head_d      = (rd_link > EmptyMark) ? EmptyMark : rd_link;
          got         = 1'b1;
        end else if (fresh_q < pool_n) begin
          res_index_d = fresh_q[IndexW-1:0];
          fresh_d     = fresh_q + CountW'(1);
          got         = 1'b1;
        end
        if (got) begin
          if (used_q < pool_n) begin
            used_tmp = used_q + CountW'(1);
          end
        end else begin
          res_status_d = STAT_EMPTY;
        end
      end
      MODE_FREE: begin
        if (CountW'(req_idx_q) < pool_n) begin
          mem_we = commit;
          head_d = LinkW'(req_idx_q);
          if (used_q != '0) begin
            used_tmp = used_q - CountW'(1);
          end
        end else begin
          res_status_d = STAT_BAD_INDEX;
        end
      end
      MODE_RESET: begin
        head_d   = EmptyMark;
        fresh_d  = '0;
        used_tmp = '0;
      end
      default: begin
      end
    endcase

    used_d       = (used_tmp > pool_n) ? pool_n : used_tmp;
    res_count_d  = pool_n - used_d;
    off_prod     = ProdW'(res_index_d) * ProdW'(stride_q);
    off_sum      = SumW'(off_prod) + SumW'(WORD_BYTES);
    res_offset_d = got ? off_sum[OffsetW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quot_q      <= XW'(QuotRst);
      stride_q    <= XW'(QuotRst * WORD_BYTES);
      biu_q       <= CountW'(256);
      head_q      <= EmptyMark;
      fresh_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      stride_q <= XW'(quot_q * XW'(WORD_BYTES));
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BLOCK_BYTES: begin
            quot_q <= quot_d;
          end
          CFG_BLOCKS_IN_USE: begin
            biu_q <= cfg_data_i[CountW-1:0];
          end
          default: begin
          end
        endcase
        head_q  <= EmptyMark;
        fresh_q <= '0;
        used_q  <= '0;
      end else if (commit) begin
        head_q  <= head_d;
        fresh_q <= fresh_d;
        used_q  <= used_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_mode_q <= mode_i;
      req_idx_q  <= free_index_i;
    end
    if (commit) begin
      res_index_q  <= res_index_d;
      res_offset_q <= res_offset_d;
      res_status_q <= res_status_d;
      res_count_q  <= res_count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_index_o  = res_index_q;
  assign block_offset_o = res_offset_q;
  assign status_o       = res_status_q;
  assign free_count_o   = res_count_q;

  assign res_fail = out_valid_o && (status_o != STAT_OK);

  `FBFL_ASSERT_IMPL(a_xfer_to_exec, in_xfer, ##1 (state_q == ST_EXEC), "Transfer not executed.")
  `FBFL_ASSERT(a_head_range, head_q <= EmptyMark, "List head beyond the empty marker.")
  `FBFL_ASSERT(a_used_range, used_q <= pool_n, "Used count exceeds the pool size.")
  `FBFL_ASSERT(a_fresh_range, fresh_q <= pool_n, "Fresh mark exceeds the pool size.")
  `FBFL_ASSERT_IMPL(a_empty_offset, res_fail, block_offset_o == '0, "Offset on failed result.")

endmodule

`default_nettype wire

FILE: design/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
